FILE: rtl/core/block_linear_texture_address_assert.svh
// assertion helpers for the texture address block
`ifndef BLOCK_LINEAR_TEXTURE_ADDRESS_ASSERT_SVH
`define BLOCK_LINEAR_TEXTURE_ADDRESS_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define BLTA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("blta assertion failed");
// condition in one cycle implies another in the next
`define BLTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blta assertion failed");
`else
`define BLTA_ASSERT(label, clk, rst_n, prop)
`define BLTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/blta_pkg.sv
`timescale 1ns / 1ps
package blta_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ADDR_BITS_DEF  = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CELL_W     = 4;
    localparam int BPC_W      = 5;
    localparam int STACK_W    = 3;

    // gob geometry
    localparam int GOB_ROWS       = 8;
    localparam int GOB_ROW_LOG2   = 3;
    localparam int GOB_WIDTH_LOG2 = 6;
    localparam int GOB_BYTES_LOG2 = 9;
    localparam int GOB_ALIGN      = 64;
    localparam int LIN_ALIGN      = 32;
    localparam int SHF_W          = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_CELL_WIDTH     = 3'd2,
        REG_CELL_HEIGHT    = 3'd3,
        REG_BYTES_PER_CELL = 3'd4,
        REG_LINEAR_MODE    = 3'd5,
        REG_PITCH_ROUND    = 3'd6,
        REG_GOB_STACK_LOG2 = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic               busy;
        logic               linear;
        logic [STACK_W-1:0] gob_log2;
        logic [BPC_W-1:0]   bpp;
    } geom_ctrl_t;

endpackage

FILE: rtl/core/blta_cfg_if.sv
`timescale 1ns / 1ps
interface blta_cfg_if import blta_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/blta_in_if.sv
`timescale 1ns / 1ps
interface blta_in_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] col_index;
    logic [COORD_BITS-1:0] row_index;

    modport source (output valid, output col_index, output row_index, input ready);
    modport sink (input valid, input col_index, input row_index, output ready);
endinterface

FILE: rtl/core/blta_out_if.sv
`timescale 1ns / 1ps
interface blta_out_if #(
    parameter int ADDR_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] tiled_addr;
    logic [ADDR_BITS-1:0] dense_addr;
    logic                 in_range;

    modport source (output valid, output tiled_addr, output dense_addr, output in_range,
                    input ready);
    modport sink (input valid, input tiled_addr, input dense_addr, input in_range,
                  output ready);
endinterface

FILE: rtl/core/blta_geom.sv
`timescale 1ns / 1ps
module blta_geom import blta_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    blta_cfg_if.sink              cfg,
    output geom_ctrl_t            ctrl,
    output logic [ADDR_BITS-1:0]  pitch,
    output logic [ADDR_BITS-1:0]  surf,
    output logic [COORD_BITS-1:0] wide,
    output logic [COORD_BITS-1:0] gobs_wide
);

    localparam int DIV_W = COORD_BITS + 1;
    localparam int RH_W  = COORD_BITS + 4;
    localparam int WB_W  = COORD_BITS + BPC_W;
    localparam int CNT_W = $clog2(RH_W);

    typedef enum logic [2:0] {
        ST_START,
        ST_DIV,
        ST_PREP,
        ST_PITCH,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [COORD_BITS-1:0] img_w_reg;
    logic [COORD_BITS-1:0] img_h_reg;
    logic [CELL_W-1:0]     cell_w_reg;
    logic [CELL_W-1:0]     cell_h_reg;
    logic [BPC_W-1:0]      bpp_reg;
    logic                  linear_reg;
    logic                  round_reg;
    logic [STACK_W-1:0]    gob_log2_reg;

    logic [DIV_W-1:0]      qw_reg;
    logic [DIV_W-1:0]      qh_reg;
    logic [CELL_W-1:0]     rw_reg;
    logic [CELL_W-1:0]     rh_reg;
    logic [COORD_BITS-1:0] wide_reg;
    logic [COORD_BITS-1:0] high_reg;
    logic [ADDR_BITS-1:0]  wb_reg;
    logic [ADDR_BITS-1:0]  pitch_reg;
    logic [COORD_BITS-1:0] gobs_reg;
    logic [ADDR_BITS-1:0]  mcand_reg;
    logic [RH_W-1:0]       mplier_reg;
    logic [ADDR_BITS-1:0]  acc_reg;

    logic                  cfg_fire;
    logic [CELL_W-1:0]     cw_eff;
    logic [CELL_W-1:0]     ch_eff;
    logic [DIV_W-1:0]      num_w;
    logic [DIV_W-1:0]      num_h;
    logic [CELL_W:0]       trial_w;
    logic [CELL_W:0]       trial_h;
    logic                  ge_w;
    logic                  ge_h;
    logic [CELL_W-1:0]     rw_next;
    logic [CELL_W-1:0]     rh_next;
    logic [DIV_W-1:0]      qw_next;
    logic [DIV_W-1:0]      qh_next;
    logic [WB_W-1:0]       wb_full;
    logic [ADDR_BITS-1:0]  wb_next;
    logic [ADDR_BITS-1:0]  lin_pitch;
    logic [ADDR_BITS-1:0]  gob_pitch;
    logic [ADDR_BITS-1:0]  pitch_next;
    logic [ADDR_BITS-1:0]  gobs_sum;
    logic [COORD_BITS-1:0] gobs_next;
    logic [RH_W-1:0]       rows_mask;
    logic [RH_W-1:0]       high_ext;
    logic [RH_W-1:0]       high_round;
    logic [RH_W-1:0]       mplier_next;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg    <= COORD_BITS'(1);
            img_h_reg    <= COORD_BITS'(1);
            cell_w_reg   <= CELL_W'(1);
            cell_h_reg   <= CELL_W'(1);
            bpp_reg      <= BPC_W'(4);
            linear_reg   <= 1'b0;
            round_reg    <= 1'b1;
            gob_log2_reg <= STACK_W'(4);
        end
        else if (cfg_fire)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_IMAGE_WIDTH:    img_w_reg    <= COORD_BITS'(cfg.data);
                REG_IMAGE_HEIGHT:   img_h_reg    <= COORD_BITS'(cfg.data);
                REG_CELL_WIDTH:     cell_w_reg   <= cfg.data[CELL_W-1:0];
                REG_CELL_HEIGHT:    cell_h_reg   <= cfg.data[CELL_W-1:0];
                REG_BYTES_PER_CELL: bpp_reg      <= cfg.data[BPC_W-1:0];
                REG_LINEAR_MODE:    linear_reg   <= cfg.data[0];
                REG_PITCH_ROUND:    round_reg    <= cfg.data[0];
                REG_GOB_STACK_LOG2: gob_log2_reg <= cfg.data[STACK_W-1:0];
                default: ;
            endcase
        end
    end

    // round-up division by the cell size, one quotient bit per cycle
    always_comb
    begin
        cw_eff  = (cell_w_reg == '0) ? CELL_W'(1) : cell_w_reg;
        ch_eff  = (cell_h_reg == '0) ? CELL_W'(1) : cell_h_reg;
        num_w   = DIV_W'(img_w_reg) + DIV_W'(cw_eff) - DIV_W'(1);
        num_h   = DIV_W'(img_h_reg) + DIV_W'(ch_eff) - DIV_W'(1);
        trial_w = {rw_reg, qw_reg[DIV_W-1]};
        trial_h = {rh_reg, qh_reg[DIV_W-1]};
        ge_w    = trial_w >= {1'b0, cw_eff};
        ge_h    = trial_h >= {1'b0, ch_eff};
        rw_next = ge_w ? CELL_W'(trial_w - {1'b0, cw_eff}) : trial_w[CELL_W-1:0];
        rh_next = ge_h ? CELL_W'(trial_h - {1'b0, ch_eff}) : trial_h[CELL_W-1:0];
        qw_next = {qw_reg[DIV_W-2:0], ge_w};
        qh_next = {qh_reg[DIV_W-2:0], ge_h};
    end

    // row bytes, pitch and height, stack-rounded in gob mode
    always_comb
    begin
        wb_full     = WB_W'(qw_reg[COORD_BITS-1:0]) * WB_W'(bpp_reg);
        wb_next     = ADDR_BITS'(wb_full);
        lin_pitch   = round_reg
                    ? ((wb_reg - ADDR_BITS'(1)) | ADDR_BITS'(LIN_ALIGN - 1)) + ADDR_BITS'(1)
                    : wb_reg;
        gob_pitch   = ((wb_reg - ADDR_BITS'(1)) | ADDR_BITS'(GOB_ALIGN - 1)) + ADDR_BITS'(1);
        pitch_next  = linear_reg ? lin_pitch : gob_pitch;
        gobs_sum    = wb_reg + ADDR_BITS'(GOB_ALIGN - 1);
        gobs_next   = COORD_BITS'(gobs_sum >> GOB_WIDTH_LOG2);
        rows_mask   = (RH_W'(GOB_ROWS) << gob_log2_reg) - RH_W'(1);
        high_ext    = RH_W'(high_reg);
        high_round  = ((high_ext - RH_W'(1)) | rows_mask) + RH_W'(1);
        mplier_next = linear_reg ? high_ext : high_round;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_START:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == CNT_W'(DIV_W - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_PREP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_PREP:  state_reg <= ST_PITCH;
                ST_PITCH:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (cnt_reg == CNT_W'(RH_W - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DONE: ;
                default: state_reg <= ST_START;
            endcase
            if (cfg_fire)
            begin
                state_reg <= ST_START;
            end
        end
    end

    // geometry datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_START:
            begin
                qw_reg <= num_w;
                qh_reg <= num_h;
                rw_reg <= '0;
                rh_reg <= '0;
            end
            ST_DIV:
            begin
                qw_reg <= qw_next;
                qh_reg <= qh_next;
                rw_reg <= rw_next;
                rh_reg <= rh_next;
            end
            ST_PREP:
            begin
                wide_reg <= qw_reg[COORD_BITS-1:0];
                high_reg <= qh_reg[COORD_BITS-1:0];
                wb_reg   <= wb_next;
            end
            ST_PITCH:
            begin
                pitch_reg  <= pitch_next;
                gobs_reg   <= gobs_next;
                mcand_reg  <= pitch_next;
                mplier_reg <= mplier_next;
                acc_reg    <= '0;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    assign ctrl.busy     = (state_reg != ST_DONE);
    assign ctrl.linear   = linear_reg;
    assign ctrl.gob_log2 = gob_log2_reg;
    assign ctrl.bpp      = bpp_reg;
    assign pitch         = pitch_reg;
    assign surf          = acc_reg;
    assign wide          = wide_reg;
    assign gobs_wide     = gobs_reg;

endmodule

FILE: rtl/core/blta_pipe.sv
`timescale 1ns / 1ps
module blta_pipe import blta_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    blta_in_if.sink               coord,
    blta_out_if.source            addr,
    input  geom_ctrl_t            ctrl,
    input  logic [ADDR_BITS-1:0]  pitch,
    input  logic [ADDR_BITS-1:0]  surf,
    input  logic [COORD_BITS-1:0] wide,
    input  logic [COORD_BITS-1:0] gobs_wide
);

    localparam int HALF    = ADDR_BITS / 2;
    localparam int UPPER   = ADDR_BITS - HALF;
    localparam int XB_W    = COORD_BITS + BPC_W;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int LIN_L_W = COORD_BITS + HALF;
    localparam int LIN_U_W = COORD_BITS + UPPER;
    localparam int DMUL_W  = ADDR_BITS + BPC_W;
    localparam int LOW_W   = GOB_BYTES_LOG2;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic accept;

    // stage 1: partial products
    logic [COORD_BITS-1:0] x1_reg;
    logic [COORD_BITS-1:0] y1_reg;
    logic [ADDR_BITS-1:0]  xb1_reg;
    logic [ADDR_BITS-1:0]  ypl1_reg;
    logic [UPPER-1:0]      yph1_reg;
    logic [ADDR_BITS-1:0]  gq1_reg;
    logic [ADDR_BITS-1:0]  yw1_reg;
    // stage 2: summed addresses
    logic [ADDR_BITS-1:0]  tiled2_reg;
    logic [ADDR_BITS-1:0]  dense2_reg;
    // stage 3: output register
    logic [ADDR_BITS-1:0]  tiled3_reg;
    logic [ADDR_BITS-1:0]  dense3_reg;
    logic                  range3_reg;

    logic [COORD_BITS-1:0] yq_in;
    logic [ADDR_BITS-1:0]  xb_in;
    logic [ADDR_BITS-1:0]  ypl_in;
    logic [UPPER-1:0]      yph_in;
    logic [ADDR_BITS-1:0]  gq_in;
    logic [ADDR_BITS-1:0]  yw_in;
    logic [ADDR_BITS-1:0]  lin_addr;
    logic [ADDR_BITS-1:0]  gob_hi;
    logic [COORD_BITS-1:0] ysub;
    logic [LOW_W-1:0]      gob_low;
    logic [ADDR_BITS-1:0]  gob_addr;
    logic [ADDR_BITS-1:0]  tiled2_next;
    logic [ADDR_BITS-1:0]  dense2_next;
    logic [ADDR_BITS-1:0]  dense3_next;
    logic [ADDR_BITS-1:0]  end_addr;
    logic                  range3_next;

    // per-stage ready so bubbles close up
    assign rdy3        = !v3_reg || addr.ready;
    assign rdy2        = !v2_reg || rdy3;
    assign rdy1        = !v1_reg || rdy2;
    assign coord.ready = rdy1 && !ctrl.busy;
    assign accept      = coord.valid && coord.ready;

    always_comb
    begin
        yq_in  = coord.row_index >> (SHF_W'(GOB_ROW_LOG2) + SHF_W'(ctrl.gob_log2));
        xb_in  = ADDR_BITS'(XB_W'(coord.col_index) * XB_W'(ctrl.bpp));
        ypl_in = ADDR_BITS'(LIN_L_W'(coord.row_index) * LIN_L_W'(pitch[HALF-1:0]));
        yph_in = UPPER'(LIN_U_W'(coord.row_index) * LIN_U_W'(pitch[ADDR_BITS-1:HALF]));
        gq_in  = ADDR_BITS'(PROD_W'(yq_in) * PROD_W'(gobs_wide));
        yw_in  = ADDR_BITS'(PROD_W'(coord.row_index) * PROD_W'(wide));
    end

    always_comb
    begin
        lin_addr    = ypl1_reg + {yph1_reg, {HALF{1'b0}}} + xb1_reg;
        gob_hi      = (gq1_reg + (xb1_reg >> GOB_WIDTH_LOG2))
                    << (SHF_W'(GOB_BYTES_LOG2) + SHF_W'(ctrl.gob_log2));
        ysub        = (y1_reg >> GOB_ROW_LOG2)
                    & ((COORD_BITS'(1) << ctrl.gob_log2) - COORD_BITS'(1));
        // byte swizzle inside one gob
        gob_low     = {xb1_reg[5], y1_reg[2:1], xb1_reg[4], y1_reg[0], xb1_reg[3:0]};
        gob_addr    = gob_hi + ADDR_BITS'({ysub, gob_low});
        tiled2_next = ctrl.linear ? lin_addr : gob_addr;
        dense2_next = yw1_reg + ADDR_BITS'(x1_reg);
    end

    always_comb
    begin
        dense3_next = ADDR_BITS'(DMUL_W'(dense2_reg) * DMUL_W'(ctrl.bpp));
        end_addr    = tiled2_reg + ADDR_BITS'(ctrl.bpp);
        range3_next = (end_addr <= surf);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= accept;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x1_reg   <= coord.col_index;
            y1_reg   <= coord.row_index;
            xb1_reg  <= xb_in;
            ypl1_reg <= ypl_in;
            yph1_reg <= yph_in;
            gq1_reg  <= gq_in;
            yw1_reg  <= yw_in;
        end
        if (rdy2 && v1_reg)
        begin
            tiled2_reg <= tiled2_next;
            dense2_reg <= dense2_next;
        end
        if (rdy3 && v2_reg)
        begin
            tiled3_reg <= tiled2_reg;
            dense3_reg <= dense3_next;
            range3_reg <= range3_next;
        end
    end

    assign addr.valid      = v3_reg;
    assign addr.tiled_addr = tiled3_reg;
    assign addr.dense_addr = dense3_reg;
    assign addr.in_range   = range3_reg;

endmodule

FILE: rtl/core/block_linear_texture_address.sv
`timescale 1ns / 1ps
// texture address generator, gob block-linear or pitch-linear layout
//
// channels: cfg writes one of eight geometry registers per beat (index, data);
// coord carries one block coordinate (col_index, row_index) per beat; addr
// returns tiled_addr, dense_addr and in_range for each coordinate, in order.
//
// throughput: one coordinate per cycle once the geometry unit has settled
// and while addr.ready is high. pipeline: three register stages (partial
// products, sums, dense scale) between coord and addr.
//
// reset and config: rst_n loads the register reset values. after reset and
// after every cfg beat the geometry unit recomputes blocks wide/high, pitch
// and surface size with a serial divider and a shift-add multiplier, with
// coord.ready low until it is done. cfg.ready is always high.
//
// stalls: addr.ready low freezes only the full stages; coord keeps being
// taken until every stage holds a beat. nothing is dropped or repeated.
`include "block_linear_texture_address_assert.svh"
module block_linear_texture_address import blta_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    blta_cfg_if.sink   cfg,
    blta_in_if.sink    coord,
    blta_out_if.source addr
);

    // user keeps geometry derived from registers stable in flight; unenforced
    geom_ctrl_t            geom_ctrl;
    logic [ADDR_BITS-1:0]  geom_pitch;
    logic [ADDR_BITS-1:0]  geom_surf;
    logic [COORD_BITS-1:0] geom_wide;
    logic [COORD_BITS-1:0] geom_gobs_wide;

    // register file plus serial divide/multiply for surface geometry
    blta_geom #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ctrl      (geom_ctrl),
        .pitch     (geom_pitch),
        .surf      (geom_surf),
        .wide      (geom_wide),
        .gobs_wide (geom_gobs_wide)
    );

    // three-stage address pipeline with per-stage valid/ready
    blta_pipe #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .coord     (coord),
        .addr      (addr),
        .ctrl      (geom_ctrl),
        .pitch     (geom_pitch),
        .surf      (geom_surf),
        .wide      (geom_wide),
        .gobs_wide (geom_gobs_wide)
    );

    // no coordinate may enter while geometry is being recomputed
    `BLTA_ASSERT(a_no_accept_busy, clk, rst_n, (coord.valid && coord.ready) |-> !geom_ctrl.busy)
    // a register write restarts the geometry unit and closes the input
    `BLTA_ASSERT_NEXT(a_cfg_closes_input, clk, rst_n, cfg.valid && cfg.ready, !coord.ready)

endmodule
